### rtl/a8pb_pkg.sv
package a8pb_pkg;

   // Register indexes on the configuration port.
   localparam logic REG_BLEND_MODE   = 1'b0;
   localparam logic REG_SOURCE_ALPHA = 1'b1;

   // Blend modes.
   localparam logic [1:0] MODE_SRC_OVER = 2'd0;
   localparam logic [1:0] MODE_SRC_COPY = 2'd1;
   localparam logic [1:0] MODE_COVERAGE = 2'd2;

   localparam logic [1:0] BLEND_MODE_RESET   = MODE_SRC_OVER;
   localparam logic [7:0] SOURCE_ALPHA_RESET = 8'd255;

   // Per-item operation, decided when the item enters the pipeline.
   localparam logic [2:0] OP_PASS      = 3'd0;  // destination untouched
   localparam logic [2:0] OP_COVERAGE  = 3'd1;  // write the coverage byte
   localparam logic [2:0] OP_MASK_OVER = 3'd2;  // lerp toward source-over
   localparam logic [2:0] OP_RUN_OVER  = 3'd3;  // source-over with folded coverage
   localparam logic [2:0] OP_COPY      = 3'd4;  // lerp toward the source alpha

   localparam logic [7:0] FULL = 8'd255;

   typedef struct packed {
      logic [2:0]  op;
      logic [7:0]  dst;
      logic [7:0]  cov;
      logic [7:0]  src;
      logic [15:0] prod_a;   // (255 - src) * dst
      logic [15:0] prod_b;   // src * cov
   } s1_type;

   typedef struct packed {
      logic [2:0] op;
      logic [7:0] dst;
      logic [7:0] cov;
      logic [7:0] src;
      logic [7:0] over;      // srcover(src, dst)
      logic [7:0] scaled;    // div255(src * cov)
   } s2_type;

   typedef struct packed {
      logic        bypass_sel;
      logic [7:0]  bypass;
      logic [15:0] prod_p;
      logic [15:0] prod_q;
      logic [7:0]  addend;
   } s3_type;

   function automatic logic [15:0] mul8(input logic [7:0] a, input logic [7:0] b);
      return 16'(a) * 16'(b);
   endfunction

   // ((p + 128) * 257) >> 16, kept to eight bits; the multiply is a shift and add.
   function automatic logic [7:0] div255(input logic [15:0] p);
      logic [16:0] q;
      logic [25:0] w;
      q = {1'b0, p} + 17'd128;
      w = {1'b0, q, 8'd0} + {9'd0, q};
      return w[23:16];
   endfunction

endpackage

### rtl/alpha8_pixel_blend.sv
// Channel   Direction  Handshake          Payload
// req       in         req_valid/stall    dst_value, coverage, from_mask
// rsp       out        rsp_valid/stall    result_value
// csr       in         csr_write_enable   csr_index, csr_write_data
//
// One item is accepted every cycle while req_stall is low. Four register stages (multiply,
// fold, multiply, round) lie between the ports; a result is presented from the round stage.
// Reset is synchronous and active high; it empties the pipeline and restores the registers.
// Each stage holds while the one after it is full and blocked, so bubbles close up and
// req_stall rises only when all four stages are full and rsp_stall is high.
module alpha8_pixel_blend (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_dst_value,
   input  logic [7:0] req_coverage,
   input  logic       req_from_mask,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_result_value,
   input  logic       csr_write_enable,
   input  logic       csr_index,
   input  logic [7:0] csr_write_data
);

   logic [1:0] blend_mode_ff;
   logic [1:0] blend_mode_in;
   logic [7:0] source_alpha_ff;
   logic [7:0] source_alpha_in;

   logic v1_ff, v2_ff, v3_ff, v4_ff;
   logic v1_in, v2_in, v3_in, v4_in;
   logic ready1, ready2, ready3, ready4;

   a8pb_pkg::s1_type s1;
   a8pb_pkg::s2_type s2;
   a8pb_pkg::s3_type s3;

   // Configuration registers. The user must see that they are only written while no item is in
   // flight, so the stages may read them directly; the block itself does not enforce this.
   always_comb begin
      blend_mode_in   = blend_mode_ff;
      source_alpha_in = source_alpha_ff;
      if (csr_write_enable) begin
         case (csr_index)
            a8pb_pkg::REG_BLEND_MODE: begin
               blend_mode_in = csr_write_data[1:0];
            end
            a8pb_pkg::REG_SOURCE_ALPHA: begin
               source_alpha_in = csr_write_data;
            end
            default: begin
               blend_mode_in = blend_mode_ff;
            end
         endcase
      end
   end

   // A stage may load when it is empty or when its contents move on in the same cycle.
   always_comb begin
      ready4 = !v4_ff || !rsp_stall;
      ready3 = !v3_ff || ready4;
      ready2 = !v2_ff || ready3;
      ready1 = !v1_ff || ready2;
      v1_in  = ready1 ? req_valid : v1_ff;
      v2_in  = ready2 ? v1_ff : v2_ff;
      v3_in  = ready3 ? v2_ff : v3_ff;
      v4_in  = ready4 ? v3_ff : v4_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         blend_mode_ff   <= a8pb_pkg::BLEND_MODE_RESET;
         source_alpha_ff <= a8pb_pkg::SOURCE_ALPHA_RESET;
         v1_ff           <= 1'b0;
         v2_ff           <= 1'b0;
         v3_ff           <= 1'b0;
         v4_ff           <= 1'b0;
      end else begin
         blend_mode_ff   <= blend_mode_in;
         source_alpha_ff <= source_alpha_in;
         v1_ff           <= v1_in;
         v2_ff           <= v2_in;
         v3_ff           <= v3_in;
         v4_ff           <= v4_in;
      end
   end

   assign req_stall = !ready1;
   assign rsp_valid = v4_ff;

   // Stage one decodes the operation and forms the two source products.
   a8pb_decode_mul u_decode_mul (
      .clock        (clock),
      .load         (ready1),
      .blend_mode   (blend_mode_ff),
      .source_alpha (source_alpha_ff),
      .dst_value    (req_dst_value),
      .coverage     (req_coverage),
      .from_mask    (req_from_mask),
      .s1           (s1)
   );

   // Stage two rounds them into the source-over value and the coverage-scaled source.
   a8pb_fold u_fold (
      .clock (clock),
      .load  (ready2),
      .s1    (s1),
      .s2    (s2)
   );

   // Stage three forms the weighted products of the final lerp.
   a8pb_lerp_mul u_lerp_mul (
      .clock (clock),
      .load  (ready3),
      .s2    (s2),
      .s3    (s3)
   );

   // Stage four sums, rounds and holds the result for the consumer.
   a8pb_round u_round (
      .clock        (clock),
      .load         (ready4),
      .s3           (s3),
      .result_value (rsp_result_value)
   );

   // The input only stalls when every stage is occupied and the output is blocked.
   a_stall_only_when_full : assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (v1_ff && v2_ff && v3_ff && v4_ff && rsp_stall))
      else $error("input stalled with room in the pipeline");

   // An item never waits in stage three in front of an empty output stage.
   a_stage3_moves : assert property (@(posedge clock) disable iff (reset)
      (v3_ff && !v4_ff) |=> v4_ff)
      else $error("item lost or held between stage three and the output");

   // An item never waits in stage two in front of an empty stage three.
   a_stage2_moves : assert property (@(posedge clock) disable iff (reset)
      (v2_ff && !v3_ff) |=> v3_ff)
      else $error("item lost or held between stage two and stage three");

endmodule

### rtl/a8pb_decode_mul.sv
module a8pb_decode_mul (
   input  logic              clock,
   input  logic              load,
   input  logic [1:0]        blend_mode,
   input  logic [7:0]        source_alpha,
   input  logic [7:0]        dst_value,
   input  logic [7:0]        coverage,
   input  logic              from_mask,
   output a8pb_pkg::s1_type  s1
);

   a8pb_pkg::s1_type s1_in;
   a8pb_pkg::s1_type s1_ff;
   logic             touched;

   always_comb begin
      touched = from_mask || (coverage != 8'd0);
      s1_in.dst    = dst_value;
      s1_in.cov    = coverage;
      s1_in.src    = source_alpha;
      s1_in.prod_a = a8pb_pkg::mul8(a8pb_pkg::FULL - source_alpha, dst_value);
      s1_in.prod_b = a8pb_pkg::mul8(source_alpha, coverage);
      case (blend_mode)
         a8pb_pkg::MODE_COVERAGE: begin
            s1_in.op = touched ? a8pb_pkg::OP_COVERAGE : a8pb_pkg::OP_PASS;
         end
         a8pb_pkg::MODE_SRC_OVER: begin
            if (from_mask) begin
               s1_in.op = a8pb_pkg::OP_MASK_OVER;
            end else if (coverage != 8'd0) begin
               s1_in.op = a8pb_pkg::OP_RUN_OVER;
            end else begin
               s1_in.op = a8pb_pkg::OP_PASS;
            end
         end
         a8pb_pkg::MODE_SRC_COPY: begin
            s1_in.op = touched ? a8pb_pkg::OP_COPY : a8pb_pkg::OP_PASS;
         end
         default: begin
            s1_in.op = a8pb_pkg::OP_PASS;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (load) begin
         s1_ff <= s1_in;
      end
   end

   assign s1 = s1_ff;

endmodule

### rtl/a8pb_fold.sv
module a8pb_fold (
   input  logic              clock,
   input  logic              load,
   input  a8pb_pkg::s1_type  s1,
   output a8pb_pkg::s2_type  s2
);

   a8pb_pkg::s2_type s2_in;
   a8pb_pkg::s2_type s2_ff;
   logic [8:0]       over_sum;

   always_comb begin
      over_sum = {1'b0, s1.src} + {1'b0, a8pb_pkg::div255(s1.prod_a)};
      s2_in.op     = s1.op;
      s2_in.dst    = s1.dst;
      s2_in.cov    = s1.cov;
      s2_in.src    = s1.src;
      s2_in.over   = over_sum[7:0];
      s2_in.scaled = a8pb_pkg::div255(s1.prod_b);
   end

   always_ff @(posedge clock) begin
      if (load) begin
         s2_ff <= s2_in;
      end
   end

   assign s2 = s2_ff;

endmodule

### rtl/a8pb_lerp_mul.sv
module a8pb_lerp_mul (
   input  logic              clock,
   input  logic              load,
   input  a8pb_pkg::s2_type  s2,
   output a8pb_pkg::s3_type  s3
);

   a8pb_pkg::s3_type s3_in;
   a8pb_pkg::s3_type s3_ff;
   logic [7:0]       weight_d;
   logic [7:0]       weight_k;
   logic [7:0]       other;

   // Every blending case is weight_d * dst + weight_k * other, plus an addend.
   always_comb begin
      weight_d          = a8pb_pkg::FULL - s2.cov;
      weight_k          = s2.cov;
      other             = 8'd0;
      s3_in.addend      = 8'd0;
      s3_in.bypass_sel  = 1'b0;
      s3_in.bypass      = s2.dst;
      case (s2.op)
         a8pb_pkg::OP_MASK_OVER: begin
            other = s2.over;
         end
         a8pb_pkg::OP_COPY: begin
            other = s2.src;
         end
         a8pb_pkg::OP_RUN_OVER: begin
            weight_d     = a8pb_pkg::FULL - s2.scaled;
            weight_k     = 8'd0;
            s3_in.addend = s2.scaled;
         end
         a8pb_pkg::OP_COVERAGE: begin
            s3_in.bypass_sel = 1'b1;
            s3_in.bypass     = s2.cov;
         end
         default: begin
            s3_in.bypass_sel = 1'b1;
         end
      endcase
      s3_in.prod_p = a8pb_pkg::mul8(weight_d, s2.dst);
      s3_in.prod_q = a8pb_pkg::mul8(weight_k, other);
   end

   always_ff @(posedge clock) begin
      if (load) begin
         s3_ff <= s3_in;
      end
   end

   assign s3 = s3_ff;

endmodule

### rtl/a8pb_round.sv
module a8pb_round (
   input  logic              clock,
   input  logic              load,
   input  a8pb_pkg::s3_type  s3,
   output logic [7:0]        result_value
);

   logic [16:0] sum;
   logic [8:0]  total;
   logic [7:0]  result_in;
   logic [7:0]  result_ff;

   // The two products never exceed 255 * 255 together, so sixteen bits hold the sum.
   always_comb begin
      sum   = {1'b0, s3.prod_p} + {1'b0, s3.prod_q};
      total = {1'b0, a8pb_pkg::div255(sum[15:0])} + {1'b0, s3.addend};
      result_in = s3.bypass_sel ? s3.bypass : total[7:0];
   end

   always_ff @(posedge clock) begin
      if (load) begin
         result_ff <= result_in;
      end
   end

   assign result_value = result_ff;

endmodule
